[hdl/bal_pkg.sv]
`timescale 1ns / 1ps

package bal_pkg;

  localparam int MAX_SAMPLES = 512;
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int SC_W        = 10;
  localparam int T_W         = 17;
  localparam int FRAC_W      = 16;
  localparam logic [T_W-1:0] ONE_T = T_W'(1 << FRAC_W);

  // squared distance and its root
  localparam int SUM_W  = 66;
  localparam int ROOT_W = 34;
  localparam int RAD_W  = 2 * ROOT_W;

  // divider: quotient never exceeds 1.0 in Q1.16
  localparam int DEN_W = 42;
  localparam int NUM_W = DEN_W + FRAC_W;
  localparam int QUO_W = T_W;

  // sample count = round(len / 2560), 2560 = 2^9 * 5
  localparam int CHORD_STEP  = 2560;
  localparam int ROUND_HALF  = 1280;
  localparam int CHORD_SHIFT = 9;
  localparam int RECIP5      = 52429;
  localparam int RECIP5_W    = 16;
  localparam int RECIP5_SH   = 18;

  localparam logic OP_BUILD = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic               op;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] c_x;
    logic signed [31:0] c_y;
    logic signed [31:0] c_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic [31:0]        query_distance;
  } in_word_t;

  typedef struct packed {
    logic [T_W-1:0]     t_param;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic               past_end;
    logic [31:0]        total_length;
    logic [SC_W-1:0]    sample_count;
  } out_word_t;

  typedef struct packed {
    logic             capture;
    logic             sq_clr;
    logic             sq_mul;
    logic             sq_acc;
    logic             sq_seg;
    logic             sqrt_start;
    logic             set_count;
    logic             div_start;
    logic             div_qry;
    logic             load_t;
    logic             set_t_end;
    logic             lerp_mul;
    logic             lerp_add;
    logic             seg_acc;
    logic             build_end;
    logic             rd_req;
    logic             lo_clr;
    logic             lo_load;
    logic             q_mul;
    logic             q_sum;
    logic             out_load;
    logic [1:0]       k;
    logic [1:0]       j;
    logic [CNT_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic sqrt_busy;
    logic div_busy;
    logic cnt_zero;
    logic n_zero;
    logic hit;
    logic last;
  } stat_t;

endpackage

[hdl/bal_sqrt.sv]
`timescale 1ns / 1ps

module bal_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [bal_pkg::SUM_W-1:0]   radicand,
  output logic                        busy,
  output logic [bal_pkg::ROOT_W-1:0]  root
);

  localparam int REM_W = bal_pkg::ROOT_W + 3;
  localparam int CW    = $clog2(bal_pkg::ROOT_W + 1);

  logic [bal_pkg::RAD_W-1:0] rad;
  logic [REM_W-1:0]          rem;
  logic [CW-1:0]             cnt;
  logic [REM_W-1:0]          rem_sh;
  logic [REM_W-1:0]          trial;
  logic [REM_W:0]            diff;

  // one root bit per cycle, two radicand bits consumed
  assign rem_sh = {rem[REM_W-3:0], rad[bal_pkg::RAD_W-1 -: 2]};
  assign trial  = {1'b0, root, 2'b01};
  assign diff   = {1'b0, rem_sh} - {1'b0, trial};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == CW'(1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= {{(bal_pkg::RAD_W - bal_pkg::SUM_W){1'b0}}, radicand};
      rem  <= '0;
      root <= '0;
      cnt  <= CW'(bal_pkg::ROOT_W);
    end else if (busy) begin
      rad  <= rad << 2;
      rem  <= diff[REM_W] ? rem_sh : diff[REM_W-1:0];
      root <= {root[bal_pkg::ROOT_W-2:0], ~diff[REM_W]};
      cnt  <= cnt - CW'(1);
    end
  end

endmodule

[hdl/bal_div.sv]
`timescale 1ns / 1ps

module bal_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [bal_pkg::NUM_W-1:0]  num,
  input  logic [bal_pkg::DEN_W-1:0]  den,
  output logic                       busy,
  output logic [bal_pkg::QUO_W-1:0]  quo
);

  localparam int DW = bal_pkg::DEN_W;
  localparam int QW = bal_pkg::QUO_W;
  localparam int CW = $clog2(QW + 1);

  logic [DW-1:0] rem;
  logic [DW-1:0] dreg;
  logic [QW-1:0] nlow;
  logic [CW-1:0] cnt;
  logic [DW:0]   r2;
  logic [DW:0]   diff;

  // quotient fits QW bits, so the upper numerator bits start below den
  assign r2   = {rem, nlow[QW-1]};
  assign diff = r2 - {1'b0, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == CW'(1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= DW'(num[bal_pkg::NUM_W-1:QW]);
      nlow <= num[QW-1:0];
      dreg <= den;
      quo  <= '0;
      cnt  <= CW'(QW);
    end else if (busy) begin
      rem  <= diff[DW] ? r2[DW-1:0] : diff[DW-1:0];
      nlow <= nlow << 1;
      quo  <= {quo[QW-2:0], ~diff[DW]};
      cnt  <= cnt - CW'(1);
    end
  end

endmodule

[hdl/bal_dp.sv]
`timescale 1ns / 1ps

module bal_dp (
  input  logic                clk,
  input  logic                rst,
  input  bal_pkg::in_word_t   in_word,
  input  bal_pkg::cmd_t       cmd,
  output bal_pkg::stat_t      st,
  output bal_pkg::out_word_t  out_word
);

  localparam int CNT_W = bal_pkg::CNT_W;
  localparam int DW    = bal_pkg::DEN_W;
  localparam int NW    = bal_pkg::NUM_W;
  localparam int RW    = bal_pkg::ROOT_W;
  localparam int V_W   = $clog2(bal_pkg::MAX_SAMPLES * 5);

  logic signed [31:0] pa [3];
  logic signed [31:0] pc [3];
  logic signed [31:0] pb [3];
  logic signed [31:0] prev [3];
  logic signed [31:0] cur [3];
  logic signed [31:0] l1, l2;
  logic               op_q;
  logic [31:0]        s;
  logic [CNT_W-1:0]   n_seg;
  logic [31:0]        total;
  logic [31:0]        cum;
  logic [bal_pkg::T_W-1:0] t;

  logic [63:0]              sq;
  logic [bal_pkg::SUM_W-1:0] sum;
  logic [31:0]        lo, rdata, numr;
  logic [DW-1:0]      p1, qd, top;
  logic signed [50:0] lprod;
  logic signed [31:0] lbase;

  logic [31:0] ltab [bal_pkg::MAX_SAMPLES];
  logic [bal_pkg::ADDR_W-1:0] addr;

  logic               sqrt_busy, div_busy;
  logic [RW-1:0]      root;
  logic [bal_pkg::QUO_W-1:0] quo;
  logic [NW-1:0]      div_num;
  logic [DW-1:0]      div_den;

  // square of one coordinate difference
  logic signed [31:0] sx, sy;
  logic signed [32:0] sd;
  logic [32:0]        smag_full;
  logic [31:0]        smag;

  // lerp operands and rounding
  logic signed [31:0] lp_in, lq_in;
  logic signed [32:0] ldiff;
  logic signed [50:0] lmul;
  logic [50:0]        lmag, lsum;
  logic [34:0]        lr, ld;
  logic signed [31:0] lres;

  // sample count from the end to end length
  logic [RW:0]            xcnt;
  logic [V_W-1:0]         vcnt;
  logic [V_W+bal_pkg::RECIP5_W-1:0] vmul;
  logic [CNT_W-1:0]       cnt_new;

  logic [RW:0]   csum;
  logic [31:0]   cum_next;
  logic [31:0]   den_raw, den1, numv;
  logic [CNT_W-1:0] im1;

  assign addr = bal_pkg::ADDR_W'(cmd.idx - CNT_W'(1));
  assign im1  = cmd.idx - CNT_W'(1);

  always_comb begin
    sx = cmd.sq_seg ? prev[cmd.k] : pa[cmd.k];
    sy = cmd.sq_seg ? cur[cmd.k]  : pb[cmd.k];
    sd = {sy[31], sy} - {sx[31], sx};
    smag_full = sd[32] ? 33'(-sd) : 33'(sd);
    smag = smag_full[31:0];
  end

  always_comb begin
    case (cmd.j)
      2'd0: begin
        lp_in = pa[cmd.k];
        lq_in = pc[cmd.k];
      end
      2'd1: begin
        lp_in = pc[cmd.k];
        lq_in = pb[cmd.k];
      end
      default: begin
        lp_in = l1;
        lq_in = l2;
      end
    endcase
    ldiff = {lq_in[31], lq_in} - {lp_in[31], lp_in};
    lmul  = ldiff * $signed({1'b0, t});
    // round half away from zero
    lmag  = lprod[50] ? 51'(-lprod) : 51'(lprod);
    lsum  = lmag + 51'd32768;
    lr    = lsum[50:16];
    ld    = lprod[50] ? 35'(-lr) : lr;
    lres  = lbase + ld[31:0];
  end

  always_comb begin
    xcnt    = (RW+1)'(root) + (RW+1)'(bal_pkg::ROUND_HALF);
    vcnt    = xcnt[bal_pkg::CHORD_SHIFT +: V_W];
    vmul    = vcnt * bal_pkg::RECIP5_W'(bal_pkg::RECIP5);
    cnt_new = (xcnt >= (RW+1)'(bal_pkg::MAX_SAMPLES * bal_pkg::CHORD_STEP))
              ? CNT_W'(bal_pkg::MAX_SAMPLES) : vmul[bal_pkg::RECIP5_SH +: CNT_W];
  end

  always_comb begin
    csum     = (RW+1)'(cum) + (RW+1)'(root);
    cum_next = (csum[RW:32] != '0) ? 32'hFFFF_FFFF : csum[31:0];
    den_raw  = rdata - lo;
    den1     = (den_raw == 32'd0) ? 32'd1 : den_raw;
    numv     = (s > lo) ? s - lo : 32'd0;
  end

  always_comb begin
    if (cmd.div_qry) begin
      div_num = NW'({top, {bal_pkg::FRAC_W{1'b0}}}) + NW'(qd >> 1);
      div_den = qd;
    end else begin
      div_num = NW'({cmd.idx, {bal_pkg::FRAC_W{1'b0}}}) + NW'(n_seg >> 1);
      div_den = DW'(n_seg);
    end
  end

  bal_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.sqrt_start),
    .radicand (sum),
    .busy     (sqrt_busy),
    .root     (root)
  );

  bal_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (quo)
  );

  always_comb begin
    st.sqrt_busy = sqrt_busy;
    st.div_busy  = div_busy;
    st.cnt_zero  = (cnt_new == '0);
    st.n_zero    = (n_seg == '0);
    st.hit       = (s <= rdata);
    st.last      = (cmd.idx == n_seg);
  end

  // curve and table state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        pa[i] <= '0;
        pc[i] <= '0;
        pb[i] <= '0;
      end
      n_seg <= '0;
      total <= '0;
    end else begin
      if (cmd.capture && in_word.op == bal_pkg::OP_BUILD) begin
        pa[0] <= in_word.a_x;
        pa[1] <= in_word.a_y;
        pa[2] <= in_word.a_z;
        pc[0] <= in_word.c_x;
        pc[1] <= in_word.c_y;
        pc[2] <= in_word.c_z;
        pb[0] <= in_word.b_x;
        pb[1] <= in_word.b_y;
        pb[2] <= in_word.b_z;
      end
      if (cmd.set_count) n_seg <= cnt_new;
      if (cmd.build_end) total <= cum;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q <= in_word.op;
      s    <= in_word.query_distance;
    end
    if (cmd.sq_clr) sum <= '0;
    if (cmd.sq_mul) sq <= smag * smag;
    if (cmd.sq_acc) sum <= sum + bal_pkg::SUM_W'(sq);
    if (cmd.set_count) begin
      cum <= '0;
      for (int i = 0; i < 3; i++) prev[i] <= pa[i];
    end
    if (cmd.seg_acc) begin
      cum <= cum_next;
      for (int i = 0; i < 3; i++) prev[i] <= cur[i];
    end
    if (cmd.set_t_end) t <= bal_pkg::ONE_T;
    if (cmd.load_t) t <= (quo > bal_pkg::ONE_T) ? bal_pkg::ONE_T : quo;
    if (cmd.lerp_mul) begin
      lprod <= lmul;
      lbase <= lp_in;
    end
    if (cmd.lerp_add) begin
      case (cmd.j)
        2'd0:    l1 <= lres;
        2'd1:    l2 <= lres;
        default: cur[cmd.k] <= lres;
      endcase
    end
    if (cmd.lo_clr) lo <= '0;
    if (cmd.lo_load) lo <= rdata;
    if (cmd.q_mul) begin
      p1   <= den1 * im1;
      qd   <= den1 * n_seg;
      numr <= numv;
    end
    if (cmd.q_sum) top <= p1 + DW'(numr);
    if (cmd.out_load) begin
      out_word.t_param      <= op_q ? t : '0;
      out_word.pos_x        <= op_q ? cur[0] : pa[0];
      out_word.pos_y        <= op_q ? cur[1] : pa[1];
      out_word.pos_z        <= op_q ? cur[2] : pa[2];
      out_word.past_end     <= op_q && (s > total);
      out_word.total_length <= total;
      out_word.sample_count <= bal_pkg::SC_W'(n_seg);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.seg_acc) ltab[addr] <= cum_next;
    if (cmd.rd_req) rdata <= ltab[addr];
  end

endmodule

[hdl/bal_ctrl.sv]
`timescale 1ns / 1ps

module bal_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           op,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  bal_pkg::stat_t st,
  output bal_pkg::cmd_t  cmd
);

  localparam int CNT_W = bal_pkg::CNT_W;

  typedef enum logic [4:0] {
    S_IDLE, S_SQ_MUL, S_SQ_ACC, S_SQ_GO, S_SQRT, S_SET_CNT, S_T_DIV, S_T_WAIT,
    S_L_MUL, S_L_ADD, S_SEG_ACC, S_BUILD_END, S_RD, S_CMP, S_Q_MUL, S_Q_SUM,
    S_Q_DIV, S_Q_WAIT, S_DONE
  } state_t;

  state_t           state;
  logic [1:0]       k, j;
  logic [CNT_W-1:0] idx;
  logic             in_seg;
  logic             qry;
  logic             out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd         = '0;
    cmd.k       = k;
    cmd.j       = j;
    cmd.idx     = idx;
    cmd.sq_seg  = in_seg;
    cmd.div_qry = qry;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          cmd.sq_clr  = 1'b1;
          cmd.lo_clr  = 1'b1;
          if (op == bal_pkg::OP_QUERY && st.n_zero) cmd.set_t_end = 1'b1;
        end
      end
      S_SQ_MUL:    cmd.sq_mul = 1'b1;
      S_SQ_ACC:    cmd.sq_acc = 1'b1;
      S_SQ_GO:     cmd.sqrt_start = 1'b1;
      S_SET_CNT:   cmd.set_count = 1'b1;
      S_T_DIV:     cmd.div_start = 1'b1;
      S_T_WAIT:    cmd.load_t = !st.div_busy;
      S_L_MUL:     cmd.lerp_mul = 1'b1;
      S_L_ADD: begin
        cmd.lerp_add = 1'b1;
        if (j == 2'd2 && k == 2'd2 && !qry) cmd.sq_clr = 1'b1;
      end
      S_SEG_ACC:   cmd.seg_acc = 1'b1;
      S_BUILD_END: cmd.build_end = 1'b1;
      S_RD:        cmd.rd_req = 1'b1;
      S_CMP: begin
        if (!st.hit) begin
          cmd.lo_load = 1'b1;
          if (st.last) cmd.set_t_end = 1'b1;
        end
      end
      S_Q_MUL:     cmd.q_mul = 1'b1;
      S_Q_SUM:     cmd.q_sum = 1'b1;
      S_Q_DIV:     cmd.div_start = 1'b1;
      S_Q_WAIT:    cmd.load_t = !st.div_busy;
      S_DONE:      cmd.out_load = out_free;
      default:     cmd.out_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      k         <= '0;
      j         <= '0;
      idx       <= '0;
      in_seg    <= 1'b0;
      qry       <= 1'b0;
    end else begin
      // in S_DONE a taken word is replaced by the new one below
      if (out_valid && !out_stall && state != S_DONE) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            qry    <= op;
            k      <= '0;
            j      <= '0;
            in_seg <= 1'b0;
            if (op == bal_pkg::OP_BUILD) begin
              state <= S_SQ_MUL;
            end else if (st.n_zero) begin
              state <= S_L_MUL;
            end else begin
              idx   <= CNT_W'(1);
              state <= S_RD;
            end
          end
        end
        S_SQ_MUL: state <= S_SQ_ACC;
        S_SQ_ACC: begin
          if (k == 2'd2) begin
            state <= S_SQ_GO;
          end else begin
            k     <= k + 2'd1;
            state <= S_SQ_MUL;
          end
        end
        S_SQ_GO: state <= S_SQRT;
        S_SQRT: begin
          if (!st.sqrt_busy) state <= in_seg ? S_SEG_ACC : S_SET_CNT;
        end
        S_SET_CNT: begin
          if (st.cnt_zero) begin
            state <= S_BUILD_END;
          end else begin
            idx    <= CNT_W'(1);
            in_seg <= 1'b1;
            state  <= S_T_DIV;
          end
        end
        S_T_DIV: state <= S_T_WAIT;
        S_T_WAIT: begin
          if (!st.div_busy) begin
            k     <= '0;
            j     <= '0;
            state <= S_L_MUL;
          end
        end
        S_L_MUL: state <= S_L_ADD;
        S_L_ADD: begin
          if (j == 2'd2) begin
            j <= '0;
            if (k == 2'd2) begin
              k     <= '0;
              state <= qry ? S_DONE : S_SQ_MUL;
            end else begin
              k     <= k + 2'd1;
              state <= S_L_MUL;
            end
          end else begin
            j     <= j + 2'd1;
            state <= S_L_MUL;
          end
        end
        S_SEG_ACC: begin
          if (st.last) begin
            state <= S_BUILD_END;
          end else begin
            idx   <= idx + CNT_W'(1);
            state <= S_T_DIV;
          end
        end
        S_BUILD_END: state <= S_DONE;
        S_RD: state <= S_CMP;
        S_CMP: begin
          if (st.hit) begin
            state <= S_Q_MUL;
          end else if (st.last) begin
            k     <= '0;
            j     <= '0;
            state <= S_L_MUL;
          end else begin
            idx   <= idx + CNT_W'(1);
            state <= S_RD;
          end
        end
        S_Q_MUL: state <= S_Q_SUM;
        S_Q_SUM: state <= S_Q_DIV;
        S_Q_DIV: state <= S_Q_WAIT;
        S_Q_WAIT: begin
          if (!st.div_busy) begin
            k     <= '0;
            j     <= '0;
            state <= S_L_MUL;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[hdl/bezier_arc_length_param.sv]
`timescale 1ns / 1ps

// channel   handshake            word
// input     in_valid / in_stall  in_word  (build points or query distance)
// output    out_valid / out_stall out_word (t, curve point, length, count)
//
// one word at a time; build time grows with the number n of segments,
// set by the serial square root (one root bit a cycle) and divider per segment
// query time grows with the number of table entries scanned, plus the divide
// and curve evaluation
// rst is synchronous: clears the stored curve to zero, the segment count and the total length
// a finished word waits in the output register while out_stall is high

module bezier_arc_length_param (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  bal_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output bal_pkg::out_word_t out_word
);

  bal_pkg::cmd_t  cmd;
  bal_pkg::stat_t st;

  bal_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .op        (in_word.op),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  bal_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_word  (in_word),
    .cmd      (cmd),
    .st       (st),
    .out_word (out_word)
  );

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;

  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int PHASE_WORDS = 97;
  localparam int HOLD_WORDS  = 31;

  typedef struct {
    bal_pkg::in_word_t  w;
    bit                 typed;
    bal_pkg::out_word_t e;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  bal_pkg::in_word_t  in_word = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  bal_pkg::out_word_t out_word;

  int        errors = 0;
  int        cycles = 0;
  int        tx_idle = 29;
  int        rx_idle = 75;
  int        hold_seq = 0;
  int        hold_seen = 0;
  int        hold_left = 0;
  int        sent = 0;

  // curve state mirrored from the block
  longint             ctl_pts[9];
  bit [31:0]          chord_sum[0:bal_pkg::MAX_SAMPLES];
  int unsigned        seg_cnt = 0;
  bal_pkg::out_word_t pending_arc[$];
  stim_row_t          rows[$];

  bezier_arc_length_param u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic longint unsigned chord(input longint p[3], input longint q[3]);
    logic [127:0]      sum;
    longint            d;
    longint unsigned   m, r, cand;
    sum = '0;
    r = 0;
    for (int k = 0; k < 3; k++) begin
      d = q[k] - p[k];
      m = d < 0 ? -d : d;
      sum += 128'(m) * 128'(m);
    end
    for (int b = 34; b >= 0; b--) begin
      cand = r | (64'd1 << b);
      if (128'(cand) * 128'(cand) <= sum) r = cand;
    end
    return r;
  endfunction

  function automatic longint mix(input longint p, input longint q, input longint t);
    longint v, d;
    v = (q - p) * t;
    d = v >= 0 ? (v + 32768) / 65536 : -((-v + 32768) / 65536);
    return p + d;
  endfunction

  function automatic void curve_at(input longint t, output longint o[3]);
    longint l1, l2;
    for (int k = 0; k < 3; k++) begin
      l1 = mix(ctl_pts[k], ctl_pts[3+k], t);
      l2 = mix(ctl_pts[3+k], ctl_pts[6+k], t);
      o[k] = mix(l1, l2, t);
    end
  endfunction

  function automatic bal_pkg::out_word_t compute_arc_result(input bal_pkg::in_word_t w);
    bal_pkg::out_word_t r;
    longint          prev[3], cur[3], a[3], b[3];
    longint unsigned span, cnt, acc, s, lo, den, num, q, top, t;
    bit              found;
    r = '0;
    t = 0;
    if (w.op == bal_pkg::OP_BUILD) begin
      ctl_pts = '{w.a_x, w.a_y, w.a_z, w.c_x, w.c_y, w.c_z, w.b_x, w.b_y, w.b_z};
      a = '{ctl_pts[0], ctl_pts[1], ctl_pts[2]};
      b = '{ctl_pts[6], ctl_pts[7], ctl_pts[8]};
      span = chord(a, b);
      cnt = (span + bal_pkg::ROUND_HALF) / bal_pkg::CHORD_STEP;
      if (cnt > bal_pkg::MAX_SAMPLES) cnt = bal_pkg::MAX_SAMPLES;
      seg_cnt = 32'(cnt);
      chord_sum[0] = 0;
      prev = a;
      for (int unsigned i = 1; i <= seg_cnt; i++) begin
        curve_at((longint'(i) * 65536 + seg_cnt / 2) / seg_cnt, cur);
        acc = longint'(chord_sum[i-1]) + chord(prev, cur);
        chord_sum[i] = acc > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : acc[31:0];
        prev = cur;
      end
      cur = a;
    end else begin
      s = w.query_distance;
      t = 65536;
      found = 0;
      for (int unsigned i = 1; i <= seg_cnt; i++) begin
        if (!found && s <= chord_sum[i]) begin
          found = 1;
          lo = chord_sum[i-1];
          den = longint'(chord_sum[i]) - lo;
          if (den == 0) begin
            t = (longint'(i - 1) * 65536 + seg_cnt / 2) / seg_cnt;
          end else begin
            num = s > lo ? s - lo : 0;
            q = den * seg_cnt;
            top = (longint'(i - 1) * den + num) * 65536;
            t = (top + q / 2) / q;
          end
        end
      end
      if (t > 65536) t = 65536;
      curve_at(t, cur);
      r.past_end = s > (seg_cnt ? chord_sum[seg_cnt] : 32'd0);
    end
    r.t_param = t[bal_pkg::T_W-1:0];
    r.pos_x = cur[0][31:0];
    r.pos_y = cur[1][31:0];
    r.pos_z = cur[2][31:0];
    r.total_length = seg_cnt ? chord_sum[seg_cnt] : 32'd0;
    r.sample_count = seg_cnt[bal_pkg::SC_W-1:0];
    return r;
  endfunction

  function automatic bal_pkg::in_word_t build_word(input int ax, ay, az, cx, cy, cz,
                                                   bx, by, bz);
    bal_pkg::in_word_t w;
    w = '{bal_pkg::OP_BUILD, ax, ay, az, cx, cy, cz, bx, by, bz, $urandom};
    return w;
  endfunction

  function automatic bal_pkg::in_word_t query_word(input bit [31:0] d, input bit junk);
    bal_pkg::in_word_t w;
    w = '0;
    if (junk) w = {1'b0, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom, $urandom};
    w.op = bal_pkg::OP_QUERY;
    w.query_distance = d;
    return w;
  endfunction

  function automatic bal_pkg::out_word_t known(input bit [bal_pkg::T_W-1:0] t,
                                               input int px, py, pz, input bit past);
    bal_pkg::out_word_t r;
    r = '{t, px, py, pz, past, 32'd0, '0};
    return r;
  endfunction

  function automatic void add_row(input bal_pkg::in_word_t w, input bit typed = 0,
                                  input bal_pkg::out_word_t e = '0);
    stim_row_t r;
    r.w = w;
    r.typed = typed;
    r.e = e;
    rows.push_back(r);
  endfunction

  task automatic send_word(input bal_pkg::in_word_t w, input bit typed = 0,
                           input bal_pkg::out_word_t e = '0, input bit no_gap = 0);
    bal_pkg::out_word_t p;
    in_word <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    p = compute_arc_result(w);
    pending_arc.push_back(typed ? e : p);
    sent++;
    if (!no_gap && $urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_arc.size() != 0) @(posedge clk);
  endtask

  function automatic bit [31:0] pick_distance();
    bit [31:0] tot;
    tot = seg_cnt ? chord_sum[seg_cnt] : 32'd0;
    case ($urandom_range(9))
      0:       return 32'd0;
      1:       return seg_cnt ? chord_sum[$urandom_range(seg_cnt)] : 32'd0;
      2:       return tot + 1;
      3:       return $urandom;
      4:       return 32'hFFFF_FFFF;
      default: return tot ? $urandom_range(tot) : $urandom_range(3);
    endcase
  endfunction

  task automatic random_words(input int count);
    int ax, ay, az, cx, cy, cz, bx, by, bz, span, nq, stop;
    stop = sent + count;
    while (sent < stop) begin
      span = 2560 * 24;
      ax = int'($urandom) >>> 1;
      ay = int'($urandom) >>> 1;
      az = int'($urandom) >>> 1;
      bx = ax + $urandom_range(2 * span) - span;
      by = ay + $urandom_range(2 * span) - span;
      bz = az + $urandom_range(2 * span) - span;
      cx = ax + $urandom_range(1 << 21) - (1 << 20);
      cy = ay + $urandom_range(1 << 21) - (1 << 20);
      cz = az + $urandom_range(1 << 21) - (1 << 20);
      if ($urandom_range(4) == 0) begin
        cx = $urandom;
        cy = $urandom;
        cz = $urandom;
      end
      // rare full-range curves hit the sample count limit and walk long tables
      if ($urandom_range(69) == 0) begin
        ax = $urandom; ay = $urandom; az = $urandom;
        bx = $urandom; by = $urandom; bz = $urandom;
      end
      send_word(build_word(ax, ay, az, cx, cy, cz, bx, by, bz));
      nq = $urandom_range(1, 6);
      repeat (nq) send_word(query_word(pick_distance(), $urandom_range(1)));
    end
  endtask

  // receiver: checks words and owns its stall, including the long hold-off
  always @(posedge clk) begin
    bal_pkg::out_word_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_arc.size() == 0) begin
        $display("%0t: unexpected word %p", $time, out_word);
        errors++;
      end else begin
        e = pending_arc.pop_front();
        if (out_word.t_param !== e.t_param) begin
          $display("%0t: t_param exp %0d got %0d", $time, e.t_param, out_word.t_param);
          errors++;
        end
        if (out_word.pos_x !== e.pos_x) begin
          $display("%0t: pos_x exp %0d got %0d", $time, e.pos_x, out_word.pos_x);
          errors++;
        end
        if (out_word.pos_y !== e.pos_y) begin
          $display("%0t: pos_y exp %0d got %0d", $time, e.pos_y, out_word.pos_y);
          errors++;
        end
        if (out_word.pos_z !== e.pos_z) begin
          $display("%0t: pos_z exp %0d got %0d", $time, e.pos_z, out_word.pos_z);
          errors++;
        end
        if (out_word.past_end !== e.past_end) begin
          $display("%0t: past_end exp %0d got %0d", $time, e.past_end, out_word.past_end);
          errors++;
        end
        if (out_word.total_length !== e.total_length) begin
          $display("%0t: total_length exp %0h got %0h", $time, e.total_length,
                   out_word.total_length);
          errors++;
        end
        if (out_word.sample_count !== e.sample_count) begin
          $display("%0t: sample_count exp %0d got %0d", $time, e.sample_count,
                   out_word.sample_count);
          errors++;
        end
      end
    end
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= 500;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= $urandom_range(99) < rx_idle;
    end
  end

  initial begin
    // empty table: before any build, then after a build at the origin
    add_row(query_word(32'd0, 0), 1, known(bal_pkg::ONE_T, 0, 0, 0, 0));
    add_row(query_word(32'hFFFF_FFFF, 0), 1, known(bal_pkg::ONE_T, 0, 0, 0, 1));
    add_row(build_word(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, known('0, 0, 0, 0, 0));
    add_row(query_word(32'd5, 0), 1, known(bal_pkg::ONE_T, 0, 0, 0, 1));
    // coincident end points give zero samples
    add_row(build_word(1000, -2000, 3000, -7, 8, 9, 1000, -2000, 3000), 1,
            known('0, 1000, -2000, 3000, 0));
    add_row(query_word(32'd0, 0), 1, known(bal_pkg::ONE_T, 1000, -2000, 3000, 0));
    // control point beyond the end: the curve folds back on itself
    add_row(build_word(0, 0, 0, 20480, 0, 0, 10240, 0, 0));
    add_row(query_word(32'd0, 0));
    add_row(query_word(32'd5000, 0));
    add_row(query_word(32'd20000, 0));
    add_row(query_word(32'hFFFF_FFFF, 0));
    // extremes: saturated count and saturated lengths
    add_row(build_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                       32'h7FFF_FFFF, 32'h8000_0000, 0,
                       32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    add_row(query_word(32'd0, 0));
    add_row(query_word(32'h7FFF_FFFF, 0));
    add_row(query_word(32'hFFFF_FFFF, 0));
    // sample count rounding edges
    add_row(build_word(0, 0, 0, 0, 0, 0, 1279, 0, 0));
    add_row(build_word(0, 0, 0, 640, 0, 0, 1280, 0, 0));
    add_row(query_word(32'd640, 0));
    add_row(build_word(0, 0, 0, 0, 3840, 0, 3839, 0, 0));
    add_row(build_word(-5, 7, 0, 0, -3840, 9, 3840, 0, -2));
    add_row(query_word(32'd1000, 1));
    add_row(query_word(32'd3000, 1));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].e);
    random_words(PHASE_WORDS - rows.size());
    wait_drained();

    tx_idle = 75;
    rx_idle = 29;
    random_words(PHASE_WORDS);
    wait_drained();

    tx_idle = 0;
    rx_idle = 0;
    send_word(build_word(0, 0, 0, 5000, 9000, 0, 25600, 0, 0));
    hold_seq <= hold_seq + 1;
    // back-to-back words while the output is held
    repeat (HOLD_WORDS - 1) send_word(query_word(pick_distance(), 1), 0, '0, 1);
    random_words(PHASE_WORDS - HOLD_WORDS);
    wait_drained();

    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[bezier_arc_length_param.f]
hdl/bal_pkg.sv
hdl/bal_sqrt.sv
hdl/bal_div.sv
hdl/bal_dp.sv
hdl/bal_ctrl.sv
hdl/bezier_arc_length_param.sv
tb/tb.sv
